### src/hsl_pkg.sv
// shared types and constants for the hsl to rgb colour converter
package hsl_pkg;

	localparam int unsigned HUE_W        = 9;
	localparam int unsigned CHAN_W       = 8;
	localparam int unsigned NUM_STAGES   = 6;
	localparam int unsigned NUM_CHAN     = 3;
	localparam int unsigned HUE_WRAP     = 360;
	localparam int unsigned PEAK_LO      = 90;
	localparam int unsigned PEAK_HI      = 270;
	localparam int unsigned FACTOR_RANGE = 30;
	localparam int unsigned CHAN_MAX     = 255;

	localparam int unsigned CHAN_RED   = 0;
	localparam int unsigned CHAN_GREEN = 1;
	localparam int unsigned CHAN_BLUE  = 2;

	// hue offsets in degrees, thirty times n
	localparam logic [HUE_W:0] CHAN_OFFSET [NUM_CHAN] = '{10'd0, 10'd240, 10'd120};

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [CHAN_W-1:0] saturation;
		logic [CHAN_W-1:0] lightness;
	} hsl_word_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_word_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} hsl_stage_en_t;

	typedef struct packed {
		logic       neg;
		logic [4:0] mag;
	} hsl_factor_t;

endpackage

### src/hsl_to_rgb_converter.sv
// top level of the hsl to rgb colour converter: stage valids, stall control, channel lanes
// Converts one colour word per clock, unless rgb_stall holds it, from hue (degrees),
// saturation and lightness (fractions of 255) to 8-bit red, green and blue. Each word
// passes through six register stages before it appears on rgb. Each stage advances
// when it is empty or the stage after it moves, so bubbles close up and hsl_stall
// rises only when all six stages hold words and rgb_stall is high; with rgb_stall low
// the sustained rate is one word per cycle, set by the single chroma multiplier and
// the per-channel factor and reciprocal multipliers, each owning one stage.
module hsl_to_rgb_converter #(
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               hsl_valid,
	output logic               hsl_stall,
	input  hsl_pkg::hsl_word_t hsl,
	output logic               rgb_valid,
	input  logic               rgb_stall,
	output hsl_pkg::rgb_word_t rgb
);
	import hsl_pkg::*;

	logic [NUM_STAGES-1:0] stage_vld_q;
	logic [NUM_STAGES-1:0] stage_adv;
	hsl_stage_en_t         en;

	logic [FRACTION_BITS-1:0] chroma_s2;
	logic [FRACTION_BITS:0]   light_s2;
	hsl_factor_t              factor_s2 [NUM_CHAN];
	logic [CHAN_W-1:0]        chan_s6   [NUM_CHAN];

	// a stage moves when empty or when the next one moves
	assign stage_adv[NUM_STAGES-1] = !stage_vld_q[NUM_STAGES-1] || !rgb_stall;
	for (genvar k = 0; k < NUM_STAGES-1; k++) begin : g_adv
		assign stage_adv[k] = !stage_vld_q[k] || stage_adv[k+1];
	end

	assign en = {stage_adv[0], stage_adv[1], stage_adv[2],
		stage_adv[3], stage_adv[4], stage_adv[5]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_adv[0]) begin
				stage_vld_q[0] <= hsl_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (stage_adv[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	assign hsl_stall = !stage_adv[0];
	assign rgb_valid = stage_vld_q[NUM_STAGES-1];

	hsl_front #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk       (clk),
		.en        (en),
		.word      (hsl),
		.chroma_s2 (chroma_s2),
		.light_s2  (light_s2),
		.factor_s2 (factor_s2)
	);

	for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
		hsl_channel #(
			.FRACTION_BITS(FRACTION_BITS)
		) u_channel (
			.clk       (clk),
			.en        (en),
			.chroma_s2 (chroma_s2),
			.light_s2  (light_s2),
			.factor_s2 (factor_s2[c]),
			.chan_s6   (chan_s6[c])
		);
	end

	assign rgb.red   = chan_s6[CHAN_RED];
	assign rgb.green = chan_s6[CHAN_GREEN];
	assign rgb.blue  = chan_s6[CHAN_BLUE];

endmodule

### src/hsl_front.sv
// front stages: fraction lookup, hue angles, chroma product and channel factors
module hsl_front #(
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic                   clk,
	input  hsl_pkg::hsl_stage_en_t en,
	input  hsl_pkg::hsl_word_t     word,
	output logic [FRACTION_BITS-1:0] chroma_s2,
	output logic [FRACTION_BITS:0]   light_s2,
	output hsl_pkg::hsl_factor_t     factor_s2 [hsl_pkg::NUM_CHAN]
);
	import hsl_pkg::*;

	localparam int unsigned FB = FRACTION_BITS;

	logic [FB:0] frac_lut [256];

	for (genvar i = 0; i < 256; i++) begin : g_lut
		localparam longint unsigned FRAC = (longint'(i) << FB) / longint'(CHAN_MAX);
		assign frac_lut[i] = (FB+1)'(FRAC);
	end

	function automatic hsl_factor_t angle_factor(input logic [HUE_W-1:0] kd);
		logic signed [HUE_W+1:0] t1;
		logic signed [HUE_W+1:0] t2;
		logic signed [HUE_W+1:0] t;
		logic signed [HUE_W+1:0] lim;
		hsl_factor_t             f;
		lim = signed'((HUE_W+2)'(FACTOR_RANGE));
		t1  = signed'({2'b00, kd}) - signed'((HUE_W+2)'(PEAK_LO));
		t2  = signed'((HUE_W+2)'(PEAK_HI)) - signed'({2'b00, kd});
		t   = (t1 < t2) ? t1 : t2;
		if (t > lim) begin
			t = lim;
		end else if (t < -lim) begin
			t = -lim;
		end
		f.neg = t[HUE_W+1];
		f.mag = t[HUE_W+1] ? 5'(-t) : 5'(t);
		return f;
	endfunction

	logic [FB:0]      sat_frac;
	logic [FB:0]      light_frac;
	logic [FB-1:0]    light_min;
	logic [HUE_W-1:0] hue_wrap;
	logic [HUE_W:0]   hue_sum [NUM_CHAN];
	logic [HUE_W-1:0] kd      [NUM_CHAN];

	logic [FB:0]      sat_s1;
	logic [FB:0]      light_s1;
	logic [FB-1:0]    min_s1;
	logic [HUE_W-1:0] kd_s1 [NUM_CHAN];

	logic [2*FB:0]    chroma_prod;

	assign sat_frac   = frac_lut[word.saturation];
	assign light_frac = frac_lut[word.lightness];
	// min(L, 1-L): the upper half of lightness maps to the upper half of L
	assign light_min  = word.lightness[CHAN_W-1] ?
		FB'(({1'b1, {FB{1'b0}}}) - light_frac) : light_frac[FB-1:0];
	assign hue_wrap   = (word.hue >= HUE_W'(HUE_WRAP)) ?
		word.hue - HUE_W'(HUE_WRAP) : word.hue;

	for (genvar c = 0; c < NUM_CHAN; c++) begin : g_angle
		assign hue_sum[c] = {1'b0, hue_wrap} + CHAN_OFFSET[c];
		assign kd[c]      = (hue_sum[c] >= (HUE_W+1)'(HUE_WRAP)) ?
			HUE_W'(hue_sum[c] - (HUE_W+1)'(HUE_WRAP)) : hue_sum[c][HUE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sat_s1   <= sat_frac;
			light_s1 <= light_frac;
			min_s1   <= light_min;
			kd_s1    <= kd;
		end
	end

	assign chroma_prod = sat_s1 * min_s1;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			chroma_s2 <= chroma_prod[2*FB-1:FB];
			light_s2  <= light_s1;
			for (int c = 0; c < NUM_CHAN; c++) begin
				factor_s2[c] <= angle_factor(kd_s1[c]);
			end
		end
	end

endmodule

### src/hsl_channel.sv
// back stages of one colour channel: factor product, divide by thirty, offset and scale
module hsl_channel #(
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic                       clk,
	input  hsl_pkg::hsl_stage_en_t     en,
	input  logic [FRACTION_BITS-1:0]   chroma_s2,
	input  logic [FRACTION_BITS:0]     light_s2,
	input  hsl_pkg::hsl_factor_t       factor_s2,
	output logic [hsl_pkg::CHAN_W-1:0] chan_s6
);
	import hsl_pkg::*;

	localparam int unsigned FB      = FRACTION_BITS;
	localparam int unsigned PROD_W  = FB + 4;
	localparam int unsigned SHIFT   = PROD_W + 5;
	localparam int unsigned RECIP_W = FB + 5;
	// reciprocal of thirty, exact for every product below 2^PROD_W
	localparam longint unsigned RECIP_FULL =
		((64'd1 << SHIFT) + longint'(FACTOR_RANGE) - 64'd1) / longint'(FACTOR_RANGE);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

	logic [FB+4:0]          mag_prod;
	logic [PROD_W+RECIP_W-1:0] div_prod;
	logic signed [FB+1:0]   chan_sum;
	logic [FB+8:0]          scaled;
	logic [CHAN_W:0]        chan_int;

	logic [PROD_W-1:0] prod_s3;
	logic [FB:0]       light_s3;
	logic              neg_s3;
	logic [FB-1:0]     delta_s4;
	logic [FB:0]       light_s4;
	logic              neg_s4;
	logic [FB:0]       level_s5;

	assign mag_prod = chroma_s2 * factor_s2.mag;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			prod_s3  <= mag_prod[PROD_W-1:0];
			light_s3 <= light_s2;
			neg_s3   <= factor_s2.neg;
		end
	end

	assign div_prod = prod_s3 * RECIP;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			delta_s4 <= div_prod[SHIFT+FB-1:SHIFT];
			light_s4 <= light_s3;
			neg_s4   <= neg_s3;
		end
	end

	assign chan_sum = neg_s4 ?
		signed'({1'b0, light_s4}) + signed'({2'b00, delta_s4}) :
		signed'({1'b0, light_s4}) - signed'({2'b00, delta_s4});

	always_ff @(posedge clk) begin
		if (en.s5) begin
			level_s5 <= chan_sum[FB+1] ? '0 : chan_sum[FB:0];
		end
	end

	// times 255 as times 256 less one
	assign scaled   = {level_s5, 8'b0} - {8'b0, level_s5};
	assign chan_int = scaled[FB+8:FB];

	always_ff @(posedge clk) begin
		if (en.s6) begin
			chan_s6 <= (chan_int > (CHAN_W+1)'(CHAN_MAX)) ?
				CHAN_W'(CHAN_MAX) : chan_int[CHAN_W-1:0];
		end
	end

endmodule

### tb/hsl_to_rgb_converter_tb.sv
// testbench for the hsl to rgb converter: directed table, random colours, bit-exact predictor
`timescale 1ns / 100ps

module hsl_to_rgb_converter_tb;

	import hsl_pkg::*;

	localparam int unsigned FRACTION_BITS = 16;
	localparam int          RANDOM_WORDS  = 1750;
	localparam int          DRAIN_CYCLES  = 20;
	localparam int          NUM_DIRECTED  = 22;

	typedef struct {
		int hue;
		int saturation;
		int lightness;
		bit typed;
		int red;
		int green;
		int blue;
	} colour_row_t;

	// typed rows: black, white and full lightness read straight off the formula
	colour_row_t colour_table [NUM_DIRECTED] = '{
		'{  0,   0,   0, 1'b1,   0,   0,   0},
		'{359, 255,   0, 1'b1,   0,   0,   0},
		'{511, 255, 255, 1'b1, 255, 255, 255},
		'{  0,   0, 255, 1'b1, 255, 255, 255},
		'{330, 254, 255, 1'b1, 255, 255, 255},
		'{  0, 255, 128, 1'b0,   0,   0,   0},
		'{ 60, 255, 128, 1'b0,   0,   0,   0},
		'{120, 255, 128, 1'b0,   0,   0,   0},
		'{180, 255, 128, 1'b0,   0,   0,   0},
		'{240, 255, 128, 1'b0,   0,   0,   0},
		'{300, 255, 128, 1'b0,   0,   0,   0},
		'{359, 255, 128, 1'b0,   0,   0,   0},
		'{360, 255, 128, 1'b0,   0,   0,   0},
		'{480, 255, 128, 1'b0,   0,   0,   0},
		'{511, 255, 128, 1'b0,   0,   0,   0},
		'{ 90, 255,   1, 1'b0,   0,   0,   0},
		'{270, 255, 254, 1'b0,   0,   0,   0},
		'{ 30, 128,  64, 1'b0,   0,   0,   0},
		'{150, 200, 200, 1'b0,   0,   0,   0},
		'{210,   1, 127, 1'b0,   0,   0,   0},
		'{256, 170,  85, 1'b0,   0,   0,   0},
		'{ 45, 255, 127, 1'b0,   0,   0,   0}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       hsl_valid;
	logic       hsl_stall;
	hsl_word_t  hsl;
	logic       rgb_valid;
	logic       rgb_stall = 1'b0;
	rgb_word_t  rgb;

	rgb_word_t  pending_rgb [$];
	int         words_sent   = 0;
	int         words_seen   = 0;
	int         hue_wraps    = 0;
	int         mismatches   = 0;
	int         burst_left   = 0;
	int         stall_run    = 0;
	int         stall_mode   = 0;

	hsl_to_rgb_converter #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsl_valid (hsl_valid),
		.hsl_stall (hsl_stall),
		.hsl       (hsl),
		.rgb_valid (rgb_valid),
		.rgb_stall (rgb_stall),
		.rgb       (rgb)
	);

	always #4 clk = ~clk;

	function automatic logic [CHAN_W-1:0] channel_level(logic [HUE_W-1:0] hue, longint l_q,
		longint a_q, int offset);
		int     deg;
		int     t;
		longint p;
		longint c;
		longint lvl;
		deg = (offset + int'(hue)) % 360;
		t = (deg - 90 < 270 - deg) ? deg - 90 : 270 - deg;
		if (t > 30)
			t = 30;
		if (t < -30)
			t = -30;
		p = (a_q * longint'(t < 0 ? -t : t)) / 30;
		c = (t < 0) ? l_q + p : l_q - p;
		if (c < 0)
			c = 0;
		lvl = (c * 255) >>> FRACTION_BITS;
		if (lvl > 255)
			lvl = 255;
		if (lvl < 0)
			lvl = 0;
		return lvl[CHAN_W-1:0];
	endfunction

	function automatic rgb_word_t predict_rgb(hsl_word_t w);
		longint    one;
		longint    s_q;
		longint    l_q;
		longint    m;
		longint    a_q;
		rgb_word_t r;
		one = longint'(1) << FRACTION_BITS;
		s_q = (longint'(w.saturation) << FRACTION_BITS) / 255;
		l_q = (longint'(w.lightness) << FRACTION_BITS) / 255;
		m = (l_q < one - l_q) ? l_q : one - l_q;
		a_q = (s_q * m) >>> FRACTION_BITS;
		r.red   = channel_level(w.hue, l_q, a_q, int'(CHAN_OFFSET[CHAN_RED]));
		r.green = channel_level(w.hue, l_q, a_q, int'(CHAN_OFFSET[CHAN_GREEN]));
		r.blue  = channel_level(w.hue, l_q, a_q, int'(CHAN_OFFSET[CHAN_BLUE]));
		return r;
	endfunction

	function automatic logic [CHAN_W-1:0] pick_byte();
		int sel;
		sel = $urandom_range(0, 15);
		case (sel)
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd1;
			3: return 8'd254;
			4: return 8'd127 + 8'($urandom_range(0, 1));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_colour(hsl_word_t w, rgb_word_t expected);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				hsl_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		hsl <= w;
		hsl_valid <= 1'b1;
		@(posedge clk);
		while (hsl_stall)
			@(posedge clk);
		pending_rgb.push_back(expected);
		words_sent++;
		if (w.hue > 9'd359)
			hue_wraps++;
	endtask

	// receiver stall pattern: runs of free flow, light, heavy and toggling stall
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_run <= $urandom_range(4, 60);
			stall_mode <= $urandom_range(0, 3);
		end else begin
			stall_run <= stall_run - 1;
		end
		case (stall_mode)
			0: rgb_stall <= 1'b0;
			1: rgb_stall <= ($urandom_range(0, 3) == 0);
			2: rgb_stall <= ($urandom_range(0, 3) != 0);
			default: rgb_stall <= ~rgb_stall;
		endcase
	end

	always @(posedge clk) begin
		rgb_word_t exp_rgb;
		if (arst_n && rgb_valid && !rgb_stall) begin
			words_seen++;
			if (pending_rgb.size() == 0) begin
				$error("unexpected rgb word %h", rgb);
				mismatches++;
			end else begin
				exp_rgb = pending_rgb.pop_front();
				if (rgb.red !== exp_rgb.red) begin
					$error("red: expected %0d, got %0d", exp_rgb.red, rgb.red);
					mismatches++;
				end
				if (rgb.green !== exp_rgb.green) begin
					$error("green: expected %0d, got %0d", exp_rgb.green, rgb.green);
					mismatches++;
				end
				if (rgb.blue !== exp_rgb.blue) begin
					$error("blue: expected %0d, got %0d", exp_rgb.blue, rgb.blue);
					mismatches++;
				end
			end
		end
	end

	initial begin
		hsl_word_t w;
		rgb_word_t r;
		arst_n <= 1'b0;
		hsl_valid <= 1'b0;
		hsl <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (colour_table[i]) begin
			w.hue        = HUE_W'(colour_table[i].hue);
			w.saturation = CHAN_W'(colour_table[i].saturation);
			w.lightness  = CHAN_W'(colour_table[i].lightness);
			if (colour_table[i].typed) begin
				r.red   = CHAN_W'(colour_table[i].red);
				r.green = CHAN_W'(colour_table[i].green);
				r.blue  = CHAN_W'(colour_table[i].blue);
			end else begin
				r = predict_rgb(w);
			end
			send_colour(w, r);
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			w.hue = ($urandom_range(0, 7) == 0) ? HUE_W'($urandom_range(360, 511))
				: HUE_W'($urandom_range(0, 359));
			w.saturation = pick_byte();
			w.lightness  = pick_byte();
			send_colour(w, predict_rgb(w));
		end
		hsl_valid <= 1'b0;

		while (pending_rgb.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d colours sent (%0d directed, %0d with hue past 359), %0d rgb words checked",
			words_sent, NUM_DIRECTED, hue_wraps, words_seen);
		$display("%0d field mismatches", mismatches);
		if (mismatches == 0 && pending_rgb.size() == 0)
			$display("hsl_to_rgb_converter_tb OK");
		else
			$display("hsl_to_rgb_converter_tb NOT OK");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d rgb words outstanding", pending_rgb.size());
		$display("hsl_to_rgb_converter_tb NOT OK");
		$finish;
	end

endmodule
